// ===== rtl/bpfm_pkg.sv =====
package bpfm_pkg;

    localparam int POOL_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 16;
    localparam int OP_BITS         = 3;
    localparam int KIND_BITS       = 2;
    localparam int PIN_BITS        = 8;
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

    typedef enum logic [OP_BITS-1:0] {
        OP_FETCH     = 3'd0,
        OP_UNPIN     = 3'd1,
        OP_FLUSH     = 3'd2,
        OP_NEW       = 3'd3,
        OP_DELETE    = 3'd4,
        OP_FLUSH_ALL = 3'd5
    } op_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_REPLY     = 2'd0,
        KIND_WRITEBACK = 2'd1,
        KIND_READ      = 2'd2,
        KIND_DEALLOC   = 2'd3
    } kind_t;

endpackage

// ===== rtl/buffer_pool_frame_manager_top.sv =====
// sequence with no output stall: new from the free deque goes from decide straight to reply;
// lookups walk one frame per cycle, so fetch, unpin, flush and delete first scan every frame,
// and lru and free-deque shifts then walk their entries one at a time
// throughput: one operation at a time, s_axis_tready high only when idle, plus output stalls
// reset (aresetn low, synchronous): no frame valid, pins and dirty bits clear, lru empty,
// free deque holds every frame in order, page counter zero
module buffer_pool_frame_manager_top #(
    parameter int POOL_FRAMES = bpfm_pkg::POOL_FRAMES_DEF,
    parameter int PAGE_BITS   = bpfm_pkg::PAGE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[2:0], page_number[18:3], dirty_mark[19], zero fill
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // target_page[15:0], frame_index[19:16], success[20], zero fill
    output logic [23:0] m_axis_tdata,
    // request_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import bpfm_pkg::*;

    localparam int FB = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
    localparam int CB = $clog2(POOL_FRAMES + 1);
    localparam logic [CB-1:0] FULL = CB'(POOL_FRAMES);
    localparam logic [FB-1:0] FLAST = FB'(POOL_FRAMES - 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SCAN   = 9'b000000010,
        ST_DECIDE = 9'b000000100,
        ST_LRUDEL = 9'b000001000,
        ST_FREESH = 9'b000010000,
        ST_FALL   = 9'b000100000,
        ST_EMIT   = 9'b001000000,
        ST_REPLY  = 9'b010000000,
        ST_WAIT   = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [PAGE_BITS-1:0] frame_page [POOL_FRAMES];
    logic [POOL_FRAMES-1:0] valid_reg, dirty_reg;
    logic [PIN_BITS-1:0]  pin_reg [POOL_FRAMES];
    logic [FB-1:0] free_reg [POOL_FRAMES];
    logic [FB-1:0] lru_reg  [POOL_FRAMES];
    logic [CB-1:0] free_cnt_reg, lru_cnt_reg;
    logic [PAGE_BITS-1:0] next_page_reg;

    logic [OP_BITS-1:0]   op_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 dmark_reg;
    logic [FB-1:0]        idx_reg;     // shared scan / flush-all pointer
    logic                 hit_reg;
    logic [FB-1:0]        frame_reg;
    logic                 ok_reg;
    logic [CB-1:0]        shift_reg;   // shift position
    logic                 rm_found_reg;
    logic                 rm_go_reg;   // on delete, push to the free deque before lru removal
    logic                 install_reg;

    logic       out_valid_reg, out_last_reg, out_ok_reg;
    logic [1:0] out_kind_reg;
    logic [15:0] out_page_reg;
    logic [3:0]  out_frame_reg;

    assign s_axis_tready = aresetn && (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_ok_reg, out_frame_reg, out_page_reg};

    // shared compare unit: one frame per cycle
    logic scan_match;
    assign scan_match = valid_reg[idx_reg] && (frame_page[idx_reg] == page_reg);

    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            free_cnt_reg  <= FULL;
            lru_cnt_reg   <= '0;
            next_page_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < POOL_FRAMES; i++) begin
                pin_reg[i]  <= '0;
                free_reg[i] <= FB'(i);
            end
        end else begin
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        op_reg    <= s_axis_tdata[2:0];
                        page_reg  <= PAGE_BITS'(s_axis_tdata[18:3]);
                        dmark_reg <= s_axis_tdata[19];
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        frame_reg <= '0;
                        install_reg <= 1'b0;
                        rm_go_reg <= 1'b0;
                        if (s_axis_tdata[2:0] == OP_FLUSH_ALL) state_reg <= ST_FALL;
                        else if (s_axis_tdata[2:0] == OP_NEW) state_reg <= ST_DECIDE;
                        else state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // lowest matching frame wins
                    if (scan_match && !hit_reg) begin
                        hit_reg   <= 1'b1;
                        frame_reg <= idx_reg;
                    end
                    if (idx_reg == FLAST) state_reg <= ST_DECIDE;
                    else idx_reg <= idx_reg + 1'b1;
                end
                ST_DECIDE: begin
                    // hold until the output register can take a victim write back
                    if (out_free) begin
                        ok_reg <= 1'b0;
                        idx_reg <= '0;
                        shift_reg <= '0;
                        rm_found_reg <= 1'b0;
                        state_reg <= ST_REPLY;
                        priority case (op_reg)
                            OP_FETCH, OP_NEW: begin
                                if (op_reg == OP_FETCH && hit_reg) begin
                                    ok_reg <= 1'b1;
                                    if (pin_reg[frame_reg] != PIN_MAX)
                                        pin_reg[frame_reg] <= pin_reg[frame_reg] + 1'b1;
                                    state_reg <= ST_LRUDEL;
                                end else if (free_cnt_reg != '0) begin
                                    frame_reg <= free_reg[FB'(free_cnt_reg - 1'b1)];
                                    free_cnt_reg <= free_cnt_reg - 1'b1;
                                    install_reg <= 1'b1;
                                    ok_reg <= 1'b1;
                                    state_reg <= (op_reg == OP_FETCH) ? ST_EMIT : ST_REPLY;
                                end else if (lru_cnt_reg != '0) begin
                                    frame_reg <= lru_reg[0];
                                    install_reg <= 1'b1;
                                    ok_reg <= 1'b1;
                                    // pop front: shift from slot 0
                                    rm_found_reg <= 1'b1;
                                    if (valid_reg[lru_reg[0]] && dirty_reg[lru_reg[0]]) begin
                                        out_valid_reg <= 1'b1;
                                        out_kind_reg  <= KIND_WRITEBACK;
                                        out_page_reg  <= 16'(frame_page[lru_reg[0]]);
                                        out_frame_reg <= 4'(lru_reg[0]);
                                        out_ok_reg    <= 1'b0;
                                        out_last_reg  <= 1'b0;
                                    end
                                    valid_reg[lru_reg[0]] <= 1'b0;
                                    state_reg <= ST_LRUDEL;
                                end else begin
                                    frame_reg <= '0;
                                end
                            end
                            OP_UNPIN: begin
                                if (!hit_reg) frame_reg <= '0;
                                else begin
                                    dirty_reg[frame_reg] <= dirty_reg[frame_reg] | dmark_reg;
                                    if (pin_reg[frame_reg] != '0) begin
                                        ok_reg <= 1'b1;
                                        pin_reg[frame_reg] <= pin_reg[frame_reg] - 1'b1;
                                        if (pin_reg[frame_reg] == PIN_BITS'(1))
                                            state_reg <= ST_WAIT;
                                    end
                                end
                            end
                            OP_FLUSH: begin
                                if (!hit_reg) frame_reg <= '0;
                                else begin
                                    ok_reg <= 1'b1;
                                    dirty_reg[frame_reg] <= 1'b0;
                                    state_reg <= ST_EMIT;
                                end
                            end
                            OP_DELETE: begin
                                if (!hit_reg) begin
                                    frame_reg <= '0;
                                    ok_reg <= 1'b1;
                                end else if (pin_reg[frame_reg] == '0) begin
                                    ok_reg <= 1'b1;
                                    valid_reg[frame_reg] <= 1'b0;
                                    dirty_reg[frame_reg] <= 1'b0;
                                    rm_go_reg <= (free_cnt_reg != FULL);
                                    shift_reg <= free_cnt_reg;
                                    state_reg <= ST_EMIT;
                                end
                            end
                            default: frame_reg <= '0;
                        endcase
                    end
                end
                ST_WAIT: begin
                    // unpin reached zero: append to lru if not present, one entry a cycle
                    if (shift_reg >= lru_cnt_reg) begin
                        if (lru_cnt_reg != FULL) begin
                            lru_reg[FB'(lru_cnt_reg)] <= frame_reg;
                            lru_cnt_reg <= lru_cnt_reg + 1'b1;
                        end
                        state_reg <= ST_REPLY;
                    end else if (lru_reg[FB'(shift_reg)] == frame_reg) begin
                        state_reg <= ST_REPLY;
                    end else begin
                        shift_reg <= shift_reg + 1'b1;
                    end
                end
                ST_LRUDEL: begin
                    // find frame_reg then close the gap, one entry a cycle while the output register is free
                    if (!out_free) begin
                        state_reg <= ST_LRUDEL;
                    end else if (!rm_found_reg) begin
                        if (shift_reg >= lru_cnt_reg) state_reg <= ST_REPLY;
                        else if (lru_reg[FB'(shift_reg)] == frame_reg) rm_found_reg <= 1'b1;
                        else shift_reg <= shift_reg + 1'b1;
                    end else if (shift_reg + 1'b1 < lru_cnt_reg) begin
                        lru_reg[FB'(shift_reg)] <= lru_reg[FB'(shift_reg + 1'b1)];
                        shift_reg <= shift_reg + 1'b1;
                    end else begin
                        lru_cnt_reg <= lru_cnt_reg - 1'b1;
                        state_reg <= (op_reg == OP_FETCH && install_reg) ? ST_EMIT : ST_REPLY;
                    end
                end
                ST_FREESH: begin
                    // push to front of free deque, shifting from the back
                    if (shift_reg != '0) begin
                        free_reg[FB'(shift_reg)] <= free_reg[FB'(shift_reg - 1'b1)];
                        shift_reg <= shift_reg - 1'b1;
                    end else begin
                        free_reg[0] <= frame_reg;
                        free_cnt_reg <= free_cnt_reg + 1'b1;
                        shift_reg <= '0;
                        rm_found_reg <= 1'b0;
                        state_reg <= ST_LRUDEL;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_page_reg  <= 16'(page_reg);
                        out_frame_reg <= 4'(frame_reg);
                        out_ok_reg    <= 1'b0;
                        out_last_reg  <= 1'b0;
                        if (op_reg == OP_FETCH) out_kind_reg <= KIND_READ;
                        else if (op_reg == OP_FLUSH) out_kind_reg <= KIND_WRITEBACK;
                        else out_kind_reg <= KIND_DEALLOC;
                        if (op_reg == OP_DELETE) begin
                            shift_reg <= rm_go_reg ? free_cnt_reg : '0;
                            rm_found_reg <= 1'b0;
                            state_reg <= rm_go_reg ? ST_FREESH : ST_LRUDEL;
                        end else begin
                            state_reg <= ST_REPLY;
                        end
                    end
                end
                ST_FALL: begin
                    if (out_free) begin
                        if (valid_reg[idx_reg]) begin
                            out_valid_reg <= 1'b1;
                            out_kind_reg  <= KIND_WRITEBACK;
                            out_page_reg  <= 16'(frame_page[idx_reg]);
                            out_frame_reg <= 4'(idx_reg);
                            out_ok_reg    <= 1'b0;
                            out_last_reg  <= 1'b0;
                            dirty_reg[idx_reg] <= 1'b0;
                        end
                        if (idx_reg == FLAST) begin
                            ok_reg <= 1'b1;
                            frame_reg <= '0;
                            page_reg <= '0;
                            state_reg <= ST_REPLY;
                        end else idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_REPLY: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_REPLY;
                        out_frame_reg <= 4'(frame_reg);
                        out_ok_reg    <= ok_reg;
                        out_last_reg  <= 1'b1;
                        // new replies with the page counter, everything else with its page
                        out_page_reg  <= (op_reg == OP_NEW) ? 16'(next_page_reg)
                                                            : 16'(page_reg);
                        if (op_reg == OP_NEW && install_reg)
                            next_page_reg <= next_page_reg + 1'b1;
                        if (install_reg) begin
                            valid_reg[frame_reg] <= 1'b1;
                            dirty_reg[frame_reg] <= 1'b0;
                            pin_reg[frame_reg]   <= PIN_BITS'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // frame page store, no reset
    always_ff @(posedge aclk) begin
        if (state_reg == ST_REPLY && out_free && install_reg)
            frame_page[frame_reg] <= (op_reg == OP_NEW) ? next_page_reg : page_reg;
    end

`ifndef ASSERT_OFF
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= FULL) else $error("free count overflow");
    a_lru_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lru_cnt_reg <= FULL) else $error("lru count overflow");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |-> state_reg != ST_REPLY)
        else $error("reply while reply pending");
`endif

endmodule

// ===== tb/sv/tb_buffer_pool_frame_manager_top.sv =====
`timescale 1ns/1ps
module tb_buffer_pool_frame_manager_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bpfm_pkg::*;

    localparam int NF = 16;

    // one result word as the block presents it
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] page;
        logic [3:0]  frame;
        logic        ok;
        logic        last;
    } result_t;

    // one directed row: the operation, and the reply when it is obvious
    typedef struct {
        logic [2:0]  op;
        logic [15:0] page;
        logic        dmark;
        bit          fixed;
        result_t     reply;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    buffer_pool_frame_manager_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 aclk = ~aclk;

    // shadow of the frame table
    logic [15:0] sh_page [NF];
    logic        sh_valid [NF];
    logic [7:0]  sh_pin [NF];
    logic        sh_dirty [NF];
    logic [3:0]  sh_free [NF];
    int          sh_free_n;
    logic [3:0]  sh_lru [$];
    logic [15:0] sh_next;

    result_t     pending_words [$];
    int          errors = 0;
    int          words_seen = 0;
    int          ops_sent = 0;
    int          send_idle = 0;    // percent of cycles the sender idles
    int          recv_stall = 0;   // percent of cycles the receiver stalls

    function automatic int find_frame(logic [15:0] pg);
        for (int f = 0; f < NF; f++)
            if (sh_valid[f] && sh_page[f] == pg) return f;
        return -1;
    endfunction

    function automatic void lru_drop(int f);
        for (int i = 0; i < sh_lru.size(); i++)
            if (sh_lru[i] == f) begin
                sh_lru.delete(i);
                return;
            end
    endfunction

    function automatic void push_word(logic [1:0] k, logic [15:0] pg, int f,
                                      logic ok, logic lst);
        result_t r;
        r.kind = k; r.page = pg; r.frame = f[3:0]; r.ok = ok; r.last = lst;
        pending_words.push_back(r);
    endfunction

    // free deque back first, else lru victim with write back if dirty
    function automatic int grab_frame();
        int f;
        if (sh_free_n > 0) begin
            sh_free_n--;
            return sh_free[sh_free_n];
        end
        if (sh_lru.size() == 0) return -1;
        f = sh_lru.pop_front();
        if (sh_valid[f] && sh_dirty[f]) push_word(KIND_WRITEBACK, sh_page[f], f, 0, 0);
        sh_valid[f] = 0;
        return f;
    endfunction

    function automatic void pool_reset();
        for (int f = 0; f < NF; f++) begin
            sh_page[f] = '0; sh_valid[f] = 0; sh_pin[f] = 0; sh_dirty[f] = 0;
            sh_free[f] = f[3:0];
        end
        sh_free_n = NF;
        sh_lru = {};
        sh_next = '0;
    endfunction

    // updates the shadow and queues the words one operation causes
    function automatic void predict_pool(logic [2:0] op, logic [15:0] pg, logic dm);
        int f;
        logic [15:0] u;
        case (op)
            OP_FETCH: begin
                f = find_frame(pg);
                if (f >= 0) begin
                    lru_drop(f);
                    if (sh_pin[f] != PIN_MAX) sh_pin[f]++;
                    push_word(KIND_REPLY, pg, f, 1, 1);
                end else begin
                    f = grab_frame();
                    if (f < 0) push_word(KIND_REPLY, pg, 0, 0, 1);
                    else begin
                        sh_page[f] = pg; sh_valid[f] = 1; sh_pin[f] = 1; sh_dirty[f] = 0;
                        push_word(KIND_READ, pg, f, 0, 0);
                        push_word(KIND_REPLY, pg, f, 1, 1);
                    end
                end
            end
            OP_UNPIN: begin
                f = find_frame(pg);
                if (f < 0) push_word(KIND_REPLY, pg, 0, 0, 1);
                else begin
                    sh_dirty[f] |= dm;
                    if (sh_pin[f] == 0) push_word(KIND_REPLY, pg, f, 0, 1);
                    else begin
                        sh_pin[f]--;
                        if (sh_pin[f] == 0) begin
                            lru_drop(f);
                            sh_lru.push_back(f[3:0]);
                        end
                        push_word(KIND_REPLY, pg, f, 1, 1);
                    end
                end
            end
            OP_FLUSH: begin
                f = find_frame(pg);
                if (f < 0) push_word(KIND_REPLY, pg, 0, 0, 1);
                else begin
                    push_word(KIND_WRITEBACK, pg, f, 0, 0);
                    sh_dirty[f] = 0;
                    push_word(KIND_REPLY, pg, f, 1, 1);
                end
            end
            OP_NEW: begin
                f = grab_frame();
                if (f < 0) push_word(KIND_REPLY, sh_next, 0, 0, 1);
                else begin
                    u = sh_next;
                    sh_next++;
                    sh_page[f] = u; sh_valid[f] = 1; sh_pin[f] = 1; sh_dirty[f] = 0;
                    push_word(KIND_REPLY, u, f, 1, 1);
                end
            end
            OP_DELETE: begin
                f = find_frame(pg);
                if (f < 0) push_word(KIND_REPLY, pg, 0, 1, 1);
                else if (sh_pin[f] > 0) push_word(KIND_REPLY, pg, f, 0, 1);
                else begin
                    sh_valid[f] = 0; sh_dirty[f] = 0;
                    push_word(KIND_DEALLOC, pg, f, 0, 0);
                    if (sh_free_n < NF) begin
                        for (int i = sh_free_n; i > 0; i--) sh_free[i] = sh_free[i-1];
                        sh_free[0] = f[3:0];
                        sh_free_n++;
                    end
                    lru_drop(f);
                    push_word(KIND_REPLY, pg, f, 1, 1);
                end
            end
            OP_FLUSH_ALL: begin
                for (int i = 0; i < NF; i++)
                    if (sh_valid[i]) begin
                        push_word(KIND_WRITEBACK, sh_page[i], i, 0, 0);
                        sh_dirty[i] = 0;
                    end
                push_word(KIND_REPLY, 16'd0, 0, 1, 1);
            end
            default: push_word(KIND_REPLY, pg, 0, 0, 1);
        endcase
    endfunction

    // sends one word, waiting out the sender's random idle cycles
    task automatic send_op(logic [2:0] op, logic [15:0] pg, logic dm);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, dm, pg, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_pool(op, pg, dm);
        ops_sent++;
    endtask

    // waits until every expected word is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // receiver: random stall and compare with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_t got, want;
                got.kind = m_axis_tuser; got.page = m_axis_tdata[15:0];
                got.frame = m_axis_tdata[19:16]; got.ok = m_axis_tdata[20];
                got.last = m_axis_tlast;
                words_seen++;
                if (pending_words.size() == 0) begin
                    $error("unexpected word kind=%0d page=%0h", got.kind, got.page);
                    errors++;
                end else begin
                    want = pending_words.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("request_kind exp %0d got %0d", want.kind, got.kind); errors++;
                    end
                    if (got.page !== want.page) begin
                        $error("target_page exp %0h got %0h", want.page, got.page); errors++;
                    end
                    if (got.frame !== want.frame) begin
                        $error("frame_index exp %0d got %0d", want.frame, got.frame); errors++;
                    end
                    if (got.ok !== want.ok) begin
                        $error("success exp %0d got %0d", want.ok, got.ok); errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last exp %0d got %0d", want.last, got.last); errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // directed rows: extremes, every operation, the odd cases
    row_t rows [19] = '{
        '{OP_UNPIN,     16'hFFFF, 1'b1, 1, '{KIND_REPLY, 16'hFFFF, 4'd0, 1'b0, 1'b1}},
        '{OP_FLUSH,     16'h0000, 1'b0, 1, '{KIND_REPLY, 16'h0000, 4'd0, 1'b0, 1'b1}},
        '{OP_DELETE,    16'h1234, 1'b0, 1, '{KIND_REPLY, 16'h1234, 4'd0, 1'b1, 1'b1}},
        '{3'd6,         16'hABCD, 1'b1, 1, '{KIND_REPLY, 16'hABCD, 4'd0, 1'b0, 1'b1}},
        '{3'd7,         16'h5555, 1'b0, 1, '{KIND_REPLY, 16'h5555, 4'd0, 1'b0, 1'b1}},
        '{OP_FLUSH_ALL, 16'h0000, 1'b0, 1, '{KIND_REPLY, 16'h0000, 4'd0, 1'b1, 1'b1}},
        '{OP_FETCH,     16'hFFFF, 1'b0, 0, '{default: '0}},
        '{OP_FETCH,     16'h0000, 1'b0, 0, '{default: '0}},
        '{OP_FETCH,     16'hFFFF, 1'b0, 0, '{default: '0}},
        '{OP_NEW,       16'h0000, 1'b0, 0, '{default: '0}},
        '{OP_UNPIN,     16'hFFFF, 1'b1, 0, '{default: '0}},
        '{OP_UNPIN,     16'hFFFF, 1'b0, 0, '{default: '0}},
        '{OP_UNPIN,     16'hFFFF, 1'b1, 0, '{default: '0}},
        '{OP_FLUSH,     16'hFFFF, 1'b0, 0, '{default: '0}},
        '{OP_DELETE,    16'h0000, 1'b0, 0, '{default: '0}},
        '{OP_UNPIN,     16'h0000, 1'b1, 0, '{default: '0}},
        '{OP_DELETE,    16'h0000, 1'b0, 0, '{default: '0}},
        '{OP_DELETE,    16'hFFFF, 1'b0, 0, '{default: '0}},
        '{OP_FLUSH_ALL, 16'h0000, 1'b0, 0, '{default: '0}}
    };

    initial begin
        logic [2:0]  op;
        logic [15:0] pg;
        int          pick;
        int          fr;
        pool_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk, fixed replies checked via the queue as well
        foreach (rows[i]) begin
            send_op(rows[i].op, rows[i].page, rows[i].dmark);
            if (rows[i].fixed && pending_words[$] !== rows[i].reply) begin
                $error("row %0d reply exp %h got %h", i, rows[i].reply, pending_words[$]);
                errors++;
            end
        end
        drain();

        // fill every frame with pins so fetch and new run out, then pin one frame again
        for (int i = 0; i < NF + 1; i++) send_op(OP_NEW, 16'd0, 1'b0);
        send_op(OP_FETCH, 16'h7777, 1'b0);
        for (int i = 0; i < 4; i++) send_op(OP_FETCH, sh_page[3], 1'b0);
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 28 : 61) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 28 : 61) : 0;
            for (int n = 0; n < 47; n++) begin
                op = 3'($urandom_range(5));
                if ($urandom_range(19) == 0) op = 3'($urandom_range(7, 6));
                pick = $urandom_range(9);
                fr = $urandom_range(NF - 1);
                // mostly pages that are resident, so unpin and delete get deep
                if (pick < 6 && sh_valid[fr]) pg = sh_page[fr];
                else if (pick < 8) pg = 16'($urandom_range(31));
                else pg = 16'($urandom);
                if (op == OP_FETCH && $urandom_range(3) == 0) op = OP_UNPIN;
                send_op(op, pg, 1'($urandom_range(1)));
            end
            drain();
        end
        $display("%0d operations sent, %0d words checked across fetch, unpin, flush,",
                 ops_sent, words_seen);
        $display("new, delete, flush all, unknown codes, pool exhaustion and repeated pins");
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
